/* hw/rtl/blockwise_gain_normalizer_unit_defines.svh */
`ifndef BLOCKWISE_GAIN_NORMALIZER_UNIT_DEFINES_SVH
`define BLOCKWISE_GAIN_NORMALIZER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define BGN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define BGN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bgn_pkg.sv */
`default_nettype none

package bgn_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ACC_W          = 64;
    localparam int PORT_W         = 32;

    typedef struct packed {
        logic busy;
        logic sat;
    } t_div_stat;

    // signed add that clamps to the 64-bit limits
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = (ACC_W + 1)'(a) + (ACC_W + 1)'(b);
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
        end else begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/bgn_div.sv */
`default_nettype none

module bgn_div #(
    parameter int VALUE_BITS = bgn_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = bgn_pkg::FRAC_BITS_DEF,
    localparam int NUM_W     = bgn_pkg::ACC_W + FRAC_BITS,
    localparam int CNT_W     = $clog2(NUM_W + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [NUM_W-1:0]           i_num,
    input  wire logic [bgn_pkg::ACC_W-1:0]  i_den,
    input  wire logic [CNT_W-1:0]           i_steps,
    output bgn_pkg::t_div_stat              o_stat,
    output logic [VALUE_BITS-1:0]           o_quot
);

    localparam int ACC_W = bgn_pkg::ACC_W;

    logic [CNT_W-1:0]      r_cnt,  n_cnt;
    logic [NUM_W-1:0]      r_num,  n_num;
    logic [ACC_W-1:0]      r_den,  n_den;
    logic [ACC_W-1:0]      r_rem,  n_rem;
    logic [VALUE_BITS-1:0] r_q,    n_q;
    logic                  r_ovf,  n_ovf;

    logic [ACC_W:0] rem_sh;
    logic [ACC_W:0] rem_sub;
    logic           ge;

    // one restoring step per cycle, numerator consumed msb first
    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = (rem_sh >= {1'b0, r_den});

        n_cnt = r_cnt;
        n_num = r_num;
        n_den = r_den;
        n_rem = r_rem;
        n_q   = r_q;
        n_ovf = r_ovf;

        if (i_start) begin
            n_cnt = i_steps;
            n_num = i_num;
            n_den = i_den;
            n_rem = '0;
            n_q   = '0;
            n_ovf = 1'b0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CNT_W'(1);
            n_num = {r_num[NUM_W-2:0], 1'b0};
            n_rem = ge ? rem_sub[ACC_W-1:0] : rem_sh[ACC_W-1:0];
            n_q   = {r_q[VALUE_BITS-2:0], ge};
            n_ovf = r_ovf | r_q[VALUE_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_ovf <= n_ovf;
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.sat  = r_ovf | r_q[VALUE_BITS-1];
    assign o_quot      = r_q;

endmodule

`default_nettype wire

/* hw/rtl/blockwise_gain_normalizer_unit.sv */
// accumulate transaction: unmasked ones skip the multiply, masked ones step through S_MUL,
// S_ACC_X and S_ACC_E; the last one of a block then computes the gain in S_GLOAD, S_DIV and
// S_FIN (S_GLOAD alone when the energy is zero); apply transaction: S_APPLY, then S_DIV if
// masked with nonzero gain, then S_FIN; one transaction at a time
// a result waits in the output register; a later apply result holds until it drains
// synchronous active-low reset: sums and gain cleared, zero-gain flag set, subtract mode off
`default_nettype none

module blockwise_gain_normalizer_unit #(
    parameter int VALUE_BITS = bgn_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = bgn_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic                               i_cfg_wr_data,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic                               i_cmd,
    input  wire logic signed [bgn_pkg::PORT_W-1:0]  i_ref_value,
    input  wire logic signed [bgn_pkg::PORT_W-1:0]  i_vol_value,
    input  wire logic                               i_in_mask,
    input  wire logic                               i_last_in_block,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [bgn_pkg::PORT_W-1:0]       o_out_value,
    output logic signed [bgn_pkg::PORT_W-1:0]       o_gain_value,
    output logic                                    o_zero_gain,
    output logic                                    o_block_end
);

    localparam int ACC_W  = bgn_pkg::ACC_W;
    localparam int PORT_W = bgn_pkg::PORT_W;
    localparam int NUM_W  = ACC_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_ACC_X = 3'd2;
    localparam logic [2:0] S_ACC_E = 3'd3;
    localparam logic [2:0] S_GLOAD = 3'd4;
    localparam logic [2:0] S_APPLY = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS - 1){1'b0}}};

    logic [2:0]                    r_state,     n_state;
    logic                          r_o_valid,   n_o_valid;
    logic signed [ACC_W-1:0]       r_cross,     n_cross;
    logic signed [ACC_W-1:0]       r_energy,    n_energy;
    logic signed [VALUE_BITS-1:0]  r_gain,      n_gain;
    logic                          r_gain_zero, n_gain_zero;
    logic                          r_sub,       n_sub;

    logic                          r_cmd;
    logic signed [VALUE_BITS-1:0]  r_ref;
    logic signed [VALUE_BITS-1:0]  r_vol;
    logic                          r_in_mask;
    logic                          r_last;
    logic signed [2*VALUE_BITS-1:0] r_prod;

    logic signed [VALUE_BITS-1:0]  r_out_value, n_out_value;
    logic signed [VALUE_BITS-1:0]  r_out_gain,  n_out_gain;
    logic                          r_out_zero,  n_out_zero;
    logic                          r_out_end,   n_out_end;

    logic                          in_acc;
    logic                          out_acc;
    logic signed [VALUE_BITS-1:0]  mul_a;
    logic signed [2*VALUE_BITS-1:0] mul_p;
    logic signed [ACC_W-1:0]       prod_ext;

    logic                          div_start;
    logic [NUM_W-1:0]              div_num;
    logic [ACC_W-1:0]              div_den;
    logic [CNT_W-1:0]              div_steps;
    bgn_pkg::t_div_stat            div_stat;
    logic [VALUE_BITS-1:0]         div_quot;

    logic                          res_neg;
    logic signed [VALUE_BITS-1:0]  div_res;
    logic [ACC_W-1:0]              cross_mag;
    logic [VALUE_BITS-1:0]         vol_mag;
    logic [VALUE_BITS-1:0]         gain_mag;
    logic                          apply_div;
    logic signed [VALUE_BITS-1:0]  adj;
    logic signed [VALUE_BITS-1:0]  adj_min;
    logic signed [VALUE_BITS:0]    diff;
    logic signed [VALUE_BITS-1:0]  sub_res;
    logic signed [VALUE_BITS-1:0]  res_val;

    bgn_div #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    assign in_acc  = i_valid && (r_state == S_IDLE);
    assign out_acc = r_o_valid && !i_stall;

    // one shared multiplier: vol*ref then ref*ref
    assign mul_a    = (r_state == S_MUL) ? r_vol : r_ref;
    assign mul_p    = mul_a * r_ref;
    assign prod_ext = ACC_W'(r_prod);

    always_comb begin
        cross_mag = r_cross[ACC_W-1] ? ACC_W'(-r_cross) : ACC_W'(r_cross);
        vol_mag   = r_vol[VALUE_BITS-1] ? VALUE_BITS'(-r_vol) : VALUE_BITS'(r_vol);
        gain_mag  = r_gain[VALUE_BITS-1] ? VALUE_BITS'(-r_gain) : VALUE_BITS'(r_gain);

        res_neg = r_cmd ? (r_vol[VALUE_BITS-1] ^ r_gain[VALUE_BITS-1]) : r_cross[ACC_W-1];
        if (div_stat.sat) begin
            div_res = res_neg ? VMIN : VMAX;
        end else begin
            div_res = res_neg ? -$signed(div_quot) : $signed(div_quot);
        end

        apply_div = r_in_mask && !r_gain_zero;
        adj       = apply_div ? div_res : r_vol;
        adj_min   = (adj < r_ref) ? adj : r_ref;
        diff      = (VALUE_BITS + 1)'(r_ref) - (VALUE_BITS + 1)'(adj_min);
        sub_res   = diff[VALUE_BITS-1] ? VMAX : diff[VALUE_BITS-1:0];

        if (r_in_mask) begin
            res_val = r_sub ? sub_res : adj;
        end else begin
            res_val = r_sub ? r_ref : r_vol;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_o_valid   = r_o_valid;
        n_cross     = r_cross;
        n_energy    = r_energy;
        n_gain      = r_gain;
        n_gain_zero = r_gain_zero;
        n_sub       = r_sub;
        n_out_value = r_out_value;
        n_out_gain  = r_out_gain;
        n_out_zero  = r_out_zero;
        n_out_end   = r_out_end;

        div_start = 1'b0;
        div_num   = {cross_mag, {FRAC_BITS{1'b0}}};
        div_den   = ACC_W'(r_energy);
        div_steps = CNT_W'(NUM_W);

        if (i_cfg_wr_en) begin
            n_sub = i_cfg_wr_data;
        end

        if (out_acc) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_cmd) begin
                        n_state = S_APPLY;
                    end else if (i_in_mask) begin
                        n_state = S_MUL;
                    end else if (i_last_in_block) begin
                        n_state = S_GLOAD;
                    end
                end
            end
            S_MUL: begin
                n_state = S_ACC_X;
            end
            S_ACC_X: begin
                n_cross = bgn_pkg::sat_add(r_cross, prod_ext);
                n_state = S_ACC_E;
            end
            S_ACC_E: begin
                n_energy = bgn_pkg::sat_add(r_energy, prod_ext);
                n_state  = r_last ? S_GLOAD : S_IDLE;
            end
            S_GLOAD: begin
                if (r_energy[ACC_W-1] || (r_energy == '0)) begin
                    n_gain      = '0;
                    n_gain_zero = 1'b1;
                    n_cross     = '0;
                    n_energy    = '0;
                    n_state     = S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_APPLY: begin
                if (apply_div) begin
                    div_start = 1'b1;
                    div_num   = {vol_mag, {(NUM_W - VALUE_BITS){1'b0}}};
                    div_den   = ACC_W'(gain_mag);
                    div_steps = CNT_W'(VALUE_BITS + FRAC_BITS);
                    n_state   = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (!div_stat.busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_cmd) begin
                    n_gain      = div_res;
                    n_gain_zero = (div_res == '0);
                    n_cross     = '0;
                    n_energy    = '0;
                    n_state     = S_IDLE;
                end else if (!r_o_valid || !i_stall) begin
                    n_o_valid   = 1'b1;
                    n_out_value = res_val;
                    n_out_gain  = r_in_mask ? r_gain : '0;
                    n_out_zero  = r_in_mask && r_gain_zero;
                    n_out_end   = r_last;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_o_valid   <= 1'b0;
            r_cross     <= '0;
            r_energy    <= '0;
            r_gain      <= '0;
            r_gain_zero <= 1'b1;
            r_sub       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_o_valid   <= n_o_valid;
            r_cross     <= n_cross;
            r_energy    <= n_energy;
            r_gain      <= n_gain;
            r_gain_zero <= n_gain_zero;
            r_sub       <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd     <= i_cmd;
            r_ref     <= i_ref_value[VALUE_BITS-1:0];
            r_vol     <= i_vol_value[VALUE_BITS-1:0];
            r_in_mask <= i_in_mask;
            r_last    <= i_last_in_block;
        end
        r_prod      <= mul_p;
        r_out_value <= n_out_value;
        r_out_gain  <= n_out_gain;
        r_out_zero  <= n_out_zero;
        r_out_end   <= n_out_end;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_out_value  = PORT_W'(r_out_value);
    assign o_gain_value = PORT_W'(r_out_gain);
    assign o_zero_gain  = r_out_zero;
    assign o_block_end  = r_out_end;

endmodule

`default_nettype wire

/* hw/rtl/bgn_chk.sv */
`default_nettype none
`include "blockwise_gain_normalizer_unit_defines.svh"

module bgn_chk (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_valid,
    input wire logic                               o_stall,
    input wire logic                               i_cmd,
    input wire logic                               i_in_mask,
    input wire logic                               i_last_in_block,
    input wire logic                               o_valid,
    input wire logic                               i_stall,
    input wire logic signed [bgn_pkg::PORT_W-1:0]  o_out_value,
    input wire logic signed [bgn_pkg::PORT_W-1:0]  o_gain_value,
    input wire logic                               o_zero_gain,
    input wire logic                               o_block_end
);

    // stalled result transaction holds
    `BGN_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_out_value) && $stable(o_gain_value) && $stable(o_block_end), "stalled result changed")

    // zero-gain flag only with a zero gain
    `BGN_ASSERT_IMP(a_zero_gain, o_valid && o_zero_gain, o_gain_value == '0, "zero_gain with nonzero gain")

    // busy right after taking an input transaction that needs work
    `BGN_ASSERT_NXT(a_busy_after_acc, i_valid && !o_stall && (i_cmd || i_in_mask || i_last_in_block), o_stall, "not busy after input transaction")

endmodule

bind blockwise_gain_normalizer_unit bgn_chk u_bgn_chk (.*);

`default_nettype wire
